>>> src/ssr_pkg.sv
// shared types and constants of the stream substring replace block
package ssr_pkg;

   localparam int MAX_PATTERN_BYTES_DEF     = 16;
   localparam int MAX_REPLACEMENT_BYTES_DEF = 16;
   localparam int STR_BYTES                 = 16;
   localparam int STR_IDX_W                 = 4;
   localparam int LEN_W                     = 5;
   localparam int CSR_DATA_W                = 64;
   localparam int CSR_ADDR_W                = 6;
   localparam int QUEUE_DEPTH               = 4;

   typedef enum logic [2:0] {
      REG_PAT_LO  = 3'd0,
      REG_PAT_HI  = 3'd1,
      REG_PAT_LEN = 3'd2,
      REG_REP_LO  = 3'd3,
      REG_REP_HI  = 3'd4,
      REG_REP_LEN = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [STR_BYTES-1:0][7:0] pattern;
      logic [LEN_W-1:0]          pattern_len;
      logic [STR_BYTES-1:0][7:0] replacement;
      logic [LEN_W-1:0]          replacement_len;
      logic                      drop_held;
   } cfg_type;

   typedef struct packed {
      logic       last;
      logic       byte_valid;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

>>> src/ssr_csr.sv
// configuration registers of the stream substring replace block
module ssr_csr #(
   parameter int MAX_PATTERN_BYTES     = ssr_pkg::MAX_PATTERN_BYTES_DEF,
   parameter int MAX_REPLACEMENT_BYTES = ssr_pkg::MAX_REPLACEMENT_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ssr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ssr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ssr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output ssr_pkg::cfg_type                  cfg
);
   import ssr_pkg::*;

   logic [CSR_DATA_W-1:0] pat_lo_ff, pat_lo_in, pat_hi_ff, pat_hi_in;
   logic [CSR_DATA_W-1:0] rep_lo_ff, rep_lo_in, rep_hi_ff, rep_hi_in;
   logic [LEN_W-1:0]      pat_len_ff, pat_len_in, rep_len_ff, rep_len_in;
   logic [LEN_W-1:0]      pat_len_act, rep_len_act;
   reg_index_type         index;
   logic                  wr_en;
   logic                  drop_held;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      pat_lo_in  = pat_lo_ff;
      pat_hi_in  = pat_hi_ff;
      pat_len_in = pat_len_ff;
      rep_lo_in  = rep_lo_ff;
      rep_hi_in  = rep_hi_ff;
      rep_len_in = rep_len_ff;
      drop_held  = 1'b0;
      if (wr_en) begin
         unique case (index)
            REG_PAT_LO: begin
               pat_lo_in = csr_pwdata;
               drop_held = 1'b1;
            end
            REG_PAT_HI: begin
               pat_hi_in = csr_pwdata;
               drop_held = 1'b1;
            end
            REG_PAT_LEN: begin
               pat_len_in = csr_pwdata[LEN_W-1:0];
               drop_held  = 1'b1;
            end
            REG_REP_LO:  rep_lo_in  = csr_pwdata;
            REG_REP_HI:  rep_hi_in  = csr_pwdata;
            REG_REP_LEN: rep_len_in = csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff  <= '0;
         pat_hi_ff  <= '0;
         pat_len_ff <= LEN_W'(1);
         rep_lo_ff  <= '0;
         rep_hi_ff  <= '0;
         rep_len_ff <= '0;
      end else begin
         pat_lo_ff  <= pat_lo_in;
         pat_hi_ff  <= pat_hi_in;
         pat_len_ff <= pat_len_in;
         rep_lo_ff  <= rep_lo_in;
         rep_hi_ff  <= rep_hi_in;
         rep_len_ff <= rep_len_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_PAT_LO:  csr_prdata = pat_lo_ff;
         REG_PAT_HI:  csr_prdata = pat_hi_ff;
         REG_PAT_LEN: csr_prdata = CSR_DATA_W'(pat_len_ff);
         REG_REP_LO:  csr_prdata = rep_lo_ff;
         REG_REP_HI:  csr_prdata = rep_hi_ff;
         REG_REP_LEN: csr_prdata = CSR_DATA_W'(rep_len_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // zero pattern length counts as one, oversized lengths saturate
   always_comb begin
      if (pat_len_ff == '0) begin
         pat_len_act = LEN_W'(1);
      end else if (pat_len_ff > LEN_W'(MAX_PATTERN_BYTES)) begin
         pat_len_act = LEN_W'(MAX_PATTERN_BYTES);
      end else begin
         pat_len_act = pat_len_ff;
      end
      if (rep_len_ff > LEN_W'(MAX_REPLACEMENT_BYTES)) begin
         rep_len_act = LEN_W'(MAX_REPLACEMENT_BYTES);
      end else begin
         rep_len_act = rep_len_ff;
      end
   end

   assign cfg.pattern         = {pat_hi_ff, pat_lo_ff};
   assign cfg.pattern_len     = pat_len_act;
   assign cfg.replacement     = {rep_hi_ff, rep_lo_ff};
   assign cfg.replacement_len = rep_len_act;
   assign cfg.drop_held       = drop_held;

endmodule

>>> src/ssr_front.sv
// input side of the stream substring replace block: accept, classify, queue
module ssr_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // in_byte
   input  logic                    req_tuser,   // in_byte_valid
   input  logic                    req_tlast,   // in_last
   input  logic                    pop,
   output ssr_pkg::queue_head_type head
);
   import ssr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop_en;
   item_type           new_item;

   assign req_tready = count_ff != CNT_W'(QUEUE_DEPTH);
   // an item with neither a byte nor an end mark has no effect and is dropped
   assign push   = req_tvalid & req_tready & (req_tuser | req_tlast);
   assign pop_en = pop & (count_ff != '0);

   assign new_item.last       = req_tlast;
   assign new_item.byte_valid = req_tuser;
   assign new_item.data       = req_tdata;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = count_ff != '0;
   assign head.item  = slot_ff[rd_ptr_ff];

endmodule

>>> src/ssr_back.sv
// match engine of the stream substring replace block: window, replace, flush
module ssr_back #(
   parameter int MAX_PATTERN_BYTES     = ssr_pkg::MAX_PATTERN_BYTES_DEF,
   parameter int MAX_REPLACEMENT_BYTES = ssr_pkg::MAX_REPLACEMENT_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ssr_pkg::cfg_type        cfg,
   input  ssr_pkg::queue_head_type head,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,   // out_byte
   output logic                    rsp_tuser,   // out_byte_valid
   output logic                    rsp_tlast    // out_last
);
   import ssr_pkg::*;

   localparam int CW  = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int IW  = $clog2(MAX_PATTERN_BYTES);
   localparam int RIW = $clog2(MAX_REPLACEMENT_BYTES);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_REPL  = 4'b0100,
      ST_FLUSH = 4'b1000
   } back_state_type;

   back_state_type   state_ff, state_in;
   logic [7:0]       win_ff [MAX_PATTERN_BYTES];
   logic [7:0]       win_in [MAX_PATTERN_BYTES];
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [RIW-1:0]   rep_idx_ff, rep_idx_in;
   logic             last_ff, last_in;
   logic             emitted_ff, emitted_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_data_ff, out_data_in;
   logic             out_user_ff, out_user_in;
   logic             out_last_ff, out_last_in;
   logic             out_free, is_prefix, window_full, rep_done, load_out, shift;
   logic [7:0]       emit_data;
   logic             emit_user, emit_last;
   back_state_type   after_item;

   assign out_free    = !out_valid_ff || rsp_tready;
   assign window_full = LEN_W'(cnt_ff) == cfg.pattern_len;
   assign rep_done    = LEN_W'(rep_idx_ff) == cfg.replacement_len - 1'b1;
   assign after_item  = last_ff ? ST_FLUSH : ST_IDLE;

   always_comb begin
      is_prefix = 1'b1;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         if (CW'(i) < cnt_ff && win_ff[i] != cfg.pattern[i]) begin
            is_prefix = 1'b0;
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      win_in     = win_ff;
      cnt_in     = cnt_ff;
      rep_idx_in = rep_idx_ff;
      last_in    = last_ff;
      emitted_in = emitted_ff;
      pop        = 1'b0;
      load_out   = 1'b0;
      shift      = 1'b0;
      emit_data  = win_ff[0];
      emit_user  = 1'b1;
      emit_last  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop        = 1'b1;
               last_in    = head.item.last;
               emitted_in = 1'b0;
               if (head.item.byte_valid) begin
                  win_in[cnt_ff[IW-1:0]] = head.item.data;
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_SCAN: begin
            if (is_prefix) begin
               if (window_full) begin
                  cnt_in = '0;
                  if (cfg.replacement_len != '0) begin
                     rep_idx_in = '0;
                     state_in   = ST_REPL;
                  end else begin
                     state_in = after_item;
                  end
               end else begin
                  state_in = after_item;
               end
            end else if (out_free) begin
               load_out   = 1'b1;
               emit_last  = last_ff && cnt_ff == CW'(1);
               shift      = 1'b1;
               emitted_in = 1'b1;
            end
         end
         ST_REPL: begin
            if (out_free) begin
               load_out   = 1'b1;
               emit_data  = cfg.replacement[STR_IDX_W'(rep_idx_ff)];
               emit_last  = last_ff && rep_done;
               emitted_in = 1'b1;
               if (rep_done) begin
                  state_in = after_item;
               end else begin
                  rep_idx_in = rep_idx_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (cnt_ff != '0) begin
               if (out_free) begin
                  load_out   = 1'b1;
                  emit_last  = cnt_ff == CW'(1);
                  shift      = 1'b1;
                  emitted_in = 1'b1;
               end
            end else if (!emitted_ff) begin
               if (out_free) begin
                  load_out  = 1'b1;
                  emit_data = '0;
                  emit_user = 1'b0;
                  emit_last = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (shift) begin
         for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         cnt_in = cnt_ff - 1'b1;
      end
      if (cfg.drop_held) begin
         cnt_in = '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      out_last_in  = out_last_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_data_in  = emit_data;
         out_user_in  = emit_user;
         out_last_in  = emit_last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
         emitted_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         last_ff      <= last_in;
         emitted_ff   <= emitted_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      rep_idx_ff  <= rep_idx_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_PATTERN_BYTES))
      else $error("window count beyond depth");

   a_idle_partial: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> LEN_W'(cnt_ff) < cfg.pattern_len)
      else $error("held window not a proper prefix length while idle");

   a_repl_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REPL |-> cnt_ff == '0)
      else $error("window not empty while emitting replacement");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (load_out && emit_last) |=> cnt_ff == '0)
      else $error("held bytes remain after final result");

endmodule

>>> src/stream_substring_replace.sv
// top level of the stream substring replace block
// Rewrites a byte stream, one byte per transfer, replacing every leftmost,
// non-overlapping occurrence of a 1 to 16 byte pattern by a 0 to 16 byte
// replacement. Bytes that may still start a match are held back, so output
// lags input by up to pattern length minus one bytes. A transfer with tlast
// flushes the held bytes and the final output transfer carries tlast; if
// nothing is left to send, a bare end marker (tuser 0, tdata 0, tlast 1) is
// sent. Input transfers with neither tuser nor tlast are dropped. The input
// side queues up to four transfers; the match engine takes a byte, checks
// the window, and emits output bytes one at a time (a mismatch emits the
// oldest held byte and re-checks; a match emits the replacement a byte per
// cycle while the output register is free), plus an end-of-string step.
// Writing the pattern registers or pattern length discards held bytes;
// configure only while the block is idle. Registers sit at byte address
// 8*i, 64-bit data, writes complete in the apb access cycle.
module stream_substring_replace #(
   parameter int MAX_PATTERN_BYTES     = ssr_pkg::MAX_PATTERN_BYTES_DEF,
   parameter int MAX_REPLACEMENT_BYTES = ssr_pkg::MAX_REPLACEMENT_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // input stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // in_byte
   input  logic                           req_tuser,   // in_byte_valid
   input  logic                           req_tlast,   // in_last
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,   // out_byte
   output logic                           rsp_tuser,   // out_byte_valid
   output logic                           rsp_tlast,   // out_last
   // configuration
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ssr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ssr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ssr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import ssr_pkg::*;

   cfg_type        cfg;
   queue_head_type head;
   logic           pop;

   // register file, also flags pattern writes that drop the held bytes
   ssr_csr #(
      .MAX_PATTERN_BYTES     (MAX_PATTERN_BYTES),
      .MAX_REPLACEMENT_BYTES (MAX_REPLACEMENT_BYTES)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // front: takes transfers, drops empty ones, queues the rest
   ssr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .pop        (pop),
      .head       (head)
   );

   // back: window compare, replacement and flush into the output register
   ssr_back #(
      .MAX_PATTERN_BYTES     (MAX_PATTERN_BYTES),
      .MAX_REPLACEMENT_BYTES (MAX_REPLACEMENT_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
